/* hdl/jkv_pkg.sv */
// Shared types, constants and helper functions of the JSON key/value extractor.
package jkv_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int KLEN_W      = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int Q_DEPTH     = 4;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW    = 3'd0,
    CFG_KEY_HIGH   = 3'd1,
    CFG_KEY_LENGTH = 3'd2,
    CFG_VALUE_KIND = 3'd3,
    CFG_DEFAULT    = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_SEEK_KEY   = 4'd0,
    PH_SEEK_COLON = 4'd1,
    PH_SKIP_SPACE = 4'd2,
    PH_STR_BODY   = 4'd3,
    PH_STR_ESC    = 4'd4,
    PH_BOOL       = 4'd5,
    PH_INT        = 4'd6,
    PH_DONE       = 4'd7,
    PH_DONE_TRUE  = 4'd8,
    PH_DONE_BAD   = 4'd9
  } phase_t;

  localparam logic [1:0] VK_STRING = 2'd0;
  localparam logic [1:0] VK_BOOL   = 2'd1;
  localparam logic [1:0] VK_INT    = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_KEY_MISSING = 3'd1;
  localparam logic [2:0] ST_NO_COLON    = 3'd2;
  localparam logic [2:0] ST_BAD_VALUE   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW    = 3'd4;

  localparam logic RK_BYTE    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef struct packed {
    logic        kind;
    logic [7:0]  value_byte;
    logic [2:0]  status;
    logic        bool_value;
    logic [31:0] int_value;
    logic        last;
  } result_t;

  // Results caused by one accepted byte: an optional string byte, then the summary if the byte ends the document.
  typedef struct packed {
    logic    byte_valid;
    result_t byte_item;
    logic    sum_valid;
    result_t sum_item;
  } scan_res_t;

  function automatic logic [7:0] true_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] d;
    priority case (b)
      CH_LOW_N: d = CH_LF;
      CH_LOW_R: d = CH_CR;
      CH_LOW_T: d = CH_TAB;
      default:  d = b;
    endcase
    return d;
  endfunction

endpackage

/* hdl/jkv_key_window.sv */
// Sliding window of recent document bytes and the quoted key token compare.
module jkv_key_window import jkv_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift_en,
  input  logic                     clear,
  input  logic [7:0]               doc_byte,
  input  logic [2*CFG_DATA_W-1:0]  key_vec,
  input  logic [KLEN_W-1:0]        key_length,
  output logic                     key_match
);

  localparam int WIN_LEN = KEY_MAX + 2;
  localparam int IDX_W   = $clog2(WIN_LEN);
  localparam int FILL_W  = $clog2(WIN_LEN + 1);

  logic [7:0]        win [WIN_LEN];
  logic [7:0]        win_next [WIN_LEN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [KLEN_W-1:0] len_c;
  logic [KLEN_W:0]   open_pos;
  logic [KLEN_W-1:0] key_idx [KEY_MAX];
  logic [KEY_MAX-1:0] byte_ok;

  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_next[i] = win[i + 1];
    end
    win_next[WIN_LEN-1] = doc_byte;
    fill_next = (fill == FILL_W'(WIN_LEN)) ? fill : fill + 1'b1;
  end

  // The token is right-aligned: the closing quote sits in the newest slot.
  always_comb begin
    len_c    = (key_length > KLEN_W'(KEY_MAX)) ? KLEN_W'(KEY_MAX) : key_length;
    open_pos = (KLEN_W+1)'(WIN_LEN - 2) - {1'b0, len_c};
    for (int m = 0; m < KEY_MAX; m++) begin
      key_idx[m] = len_c - KLEN_W'(m) - 1'b1;
      byte_ok[m] = (KLEN_W'(m) >= len_c) ||
                   (win_next[WIN_LEN-2-m] == key_vec[8*key_idx[m][3:0] +: 8]);
    end
    key_match = ((KLEN_W+1)'(fill_next) >= ({1'b0, len_c} + (KLEN_W+1)'(2))) &&
                (win_next[open_pos[IDX_W-1:0]] == CH_QUOTE) &&
                (win_next[WIN_LEN-1] == CH_QUOTE) && (&byte_ok);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win[i] <= '0;
      end
    end else if (shift_en) begin
      fill <= fill_next;
      for (int i = 0; i < WIN_LEN; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

/* hdl/jkv_parser.sv */
// Phase machine that follows the key to its value and decodes it.
module jkv_parser import jkv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  doc_byte,
  input  logic        end_of_document,
  input  logic        key_match,
  input  logic [1:0]  value_kind,
  input  logic [31:0] default_int,
  output logic        seeking,
  output scan_res_t   scan_res
);

  phase_t      phase, phase_next, phase_fin;
  logic [31:0] int_accum, int_accum_next;
  logic        is_negative, is_negative_next;
  logic        saw_digit, saw_digit_next;
  logic        overflowed, overflowed_next;
  logic [2:0]  true_index, true_index_next;

  logic        is_digit;
  logic [35:0] acc_prod;
  logic [35:0] acc_limit;
  logic        acc_ovf;
  logic        emit;
  logic [7:0]  emit_byte;
  logic [2:0]  st;
  logic        bv;
  logic [31:0] iv;

  assign seeking   = (phase == PH_SEEK_KEY);
  assign is_digit  = (doc_byte >= CH_ZERO) && (doc_byte <= CH_NINE);
  assign acc_prod  = {1'b0, int_accum, 3'b000} + {3'b000, int_accum, 1'b0} +
                     {28'd0, doc_byte - CH_ZERO};
  assign acc_limit = is_negative ? 36'h080000000 : 36'h07FFFFFFF;
  assign acc_ovf   = overflowed || (acc_prod > acc_limit);

  always_comb begin
    phase_next       = phase;
    int_accum_next   = int_accum;
    is_negative_next = is_negative;
    saw_digit_next   = saw_digit;
    overflowed_next  = overflowed;
    true_index_next  = true_index;
    unique case (phase)
      PH_SEEK_KEY: begin
        if (key_match) phase_next = PH_SEEK_COLON;
      end
      PH_SEEK_COLON: begin
        if (doc_byte == CH_COLON) phase_next = PH_SKIP_SPACE;
      end
      PH_SKIP_SPACE: begin
        if (doc_byte != CH_SPACE) begin
          if (value_kind == VK_BOOL) begin
            true_index_next = '0;
            if (doc_byte == true_char(3'd0)) begin
              phase_next      = PH_BOOL;
              true_index_next = 3'd1;
            end else begin
              phase_next = PH_DONE;
            end
          end else if (value_kind == VK_INT) begin
            if (doc_byte == CH_MINUS) begin
              phase_next       = PH_INT;
              is_negative_next = 1'b1;
            end else if (is_digit) begin
              phase_next      = PH_INT;
              int_accum_next  = acc_prod[31:0];
              overflowed_next = acc_ovf;
              saw_digit_next  = 1'b1;
            end else begin
              phase_next = saw_digit ? PH_DONE : PH_DONE_BAD;
            end
          end else begin
            phase_next = (doc_byte == CH_QUOTE) ? PH_STR_BODY : PH_DONE_BAD;
          end
        end
      end
      PH_STR_BODY: begin
        if (doc_byte == CH_BSLASH) phase_next = PH_STR_ESC;
        else if (doc_byte == CH_QUOTE) phase_next = PH_DONE;
      end
      PH_STR_ESC: begin
        phase_next = PH_STR_BODY;
      end
      PH_BOOL: begin
        if (true_index < 3'd4 && doc_byte == true_char(true_index)) begin
          true_index_next = true_index + 1'b1;
          if (true_index == 3'd3) phase_next = PH_DONE_TRUE;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          int_accum_next  = acc_prod[31:0];
          overflowed_next = acc_ovf;
          saw_digit_next  = 1'b1;
        end else begin
          phase_next = saw_digit ? PH_DONE : PH_DONE_BAD;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_byte = doc_byte;
    if (phase == PH_STR_BODY) begin
      emit = (doc_byte != CH_BSLASH) && (doc_byte != CH_QUOTE);
    end else if (phase == PH_STR_ESC) begin
      emit      = 1'b1;
      emit_byte = unescape(doc_byte);
    end

    // An integer still open at document end is closed here.
    if (phase_next == PH_INT) phase_fin = saw_digit_next ? PH_DONE : PH_DONE_BAD;
    else phase_fin = phase_next;

    priority case (phase_fin)
      PH_SEEK_KEY:            st = ST_KEY_MISSING;
      PH_SEEK_COLON:          st = ST_NO_COLON;
      PH_DONE, PH_DONE_TRUE:  st = ST_OK;
      default:                st = ST_BAD_VALUE;
    endcase

    bv = 1'b0;
    iv = '0;
    if (value_kind == VK_BOOL) begin
      bv = (phase_fin == PH_DONE_TRUE);
    end else if (value_kind == VK_INT) begin
      if (st != ST_OK) begin
        iv = default_int;
      end else begin
        iv = is_negative_next ? (32'd0 - int_accum_next) : int_accum_next;
        if (overflowed_next) st = ST_OVERFLOW;
      end
    end

    scan_res.byte_valid = take && emit;
    scan_res.byte_item  = '{kind: RK_BYTE, value_byte: emit_byte, status: ST_OK,
                            bool_value: 1'b0, int_value: 32'd0, last: 1'b0};
    scan_res.sum_valid  = take && end_of_document;
    scan_res.sum_item   = '{kind: RK_SUMMARY, value_byte: 8'd0, status: st,
                            bool_value: bv, int_value: iv, last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_document)) begin
      phase       <= PH_SEEK_KEY;
      int_accum   <= '0;
      is_negative <= 1'b0;
      saw_digit   <= 1'b0;
      overflowed  <= 1'b0;
      true_index  <= '0;
    end else if (take) begin
      phase       <= phase_next;
      int_accum   <= int_accum_next;
      is_negative <= is_negative_next;
      saw_digit   <= saw_digit_next;
      overflowed  <= overflowed_next;
      true_index  <= true_index_next;
    end
  end

endmodule

/* hdl/jkv_result_queue.sv */
// Small result queue that takes up to two results a cycle and releases one while out_ready is high.
module jkv_result_queue import jkv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  scan_res_t scan_res,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_item
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  result_t          q [Q_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count, count_next;
  logic             push0, push1, pop;
  result_t          item0;

  assign room      = (count <= CNT_W'(Q_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_item  = q[rptr];
  assign pop       = out_valid && out_ready;
  assign push0     = scan_res.byte_valid || scan_res.sum_valid;
  assign push1     = scan_res.byte_valid && scan_res.sum_valid;
  assign item0     = scan_res.byte_valid ? scan_res.byte_item : scan_res.sum_item;
  assign count_next = count + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push0) q[wptr] <= item0;
    if (push1) q[wptr + 1'b1] <= scan_res.sum_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push0) + PTR_W'(push1);
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

endmodule

/* hdl/json_key_value_extractor_top.sv */
// Top level of the JSON key/value extractor: configuration, scanner and result queue.
//
//   channel   direction  transaction carries
//   s_axis    in         tdata[7:0] doc_byte, tlast end_of_document
//   m_axis    out        tdata value_byte/status/bool_value/int_value, tuser result_kind,
//                        tlast last
//   cfg       in         cfg_index selects the register, cfg_data the value
//
// One document byte is taken every s_axis handshake cycle; its results enter the queue on
// the same edge and are offered from the next cycle. A final byte inside a string gives
// two results. s_axis_tready drops while the four-entry queue has fewer than two free
// slots, so with m_axis stalled the input stops once three or more results are waiting.
// Synchronous reset clears the scan state, the queue and the configuration registers.
module json_key_value_extractor_top import jkv_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] doc_byte
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [7:0] value_byte, [10:8] status,
                                                 // [11] bool_value, [43:12] int_value
  output logic                   m_axis_tuser,   // [0] result_kind
  output logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0] key_bytes_low, key_bytes_high;
  logic [KLEN_W-1:0]     key_length;
  logic [1:0]            value_kind;
  logic signed [31:0]    default_int;

  logic      take, seeking, key_match, room;
  scan_res_t scan_res;
  result_t   out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes_low  <= '0;
      key_bytes_high <= '0;
      key_length     <= '0;
      value_kind     <= '0;
      default_int    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:    key_bytes_low  <= cfg_data;
        CFG_KEY_HIGH:   key_bytes_high <= cfg_data;
        CFG_KEY_LENGTH: key_length     <= cfg_data[KLEN_W-1:0];
        CFG_VALUE_KIND: value_kind     <= cfg_data[1:0];
        CFG_DEFAULT:    default_int    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && s_axis_tready;

  jkv_key_window #(.KEY_MAX(KEY_MAX)) u_window (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (take && seeking),
    .clear      (take && s_axis_tlast),
    .doc_byte   (s_axis_tdata[7:0]),
    .key_vec    ({key_bytes_high, key_bytes_low}),
    .key_length (key_length),
    .key_match  (key_match)
  );

  jkv_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .doc_byte        (s_axis_tdata[7:0]),
    .end_of_document (s_axis_tlast),
    .key_match       (key_match),
    .value_kind      (value_kind),
    .default_int     (default_int),
    .seeking         (seeking),
    .scan_res        (scan_res)
  );

  jkv_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .scan_res  (scan_res),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tdata = {4'b0000, out_item.int_value, out_item.bool_value,
                         out_item.status, out_item.value_byte};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.last;

endmodule

/* hdl/jkv_checker.sv */
// Port-level checks on the extractor's result stream, bound to the top level.
module jkv_checker import jkv_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // Nothing is offered straight after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Only the summary closes a run.
  a_summary_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
    else $error("result kind and last disagree");

  a_byte_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == RK_BYTE) |-> (m_axis_tdata[43:8] == '0))
    else $error("string byte result carries summary fields");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[10:8] <= ST_OVERFLOW))
    else $error("status code out of range");

endmodule

bind json_key_value_extractor_top jkv_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
